// File: sv/dtsa_pkg.sv
// ----------------------------------------------------------------------------
// dtsa_pkg
// Shared widths, character codes, control types and the power-of-ten table
// for the decimal token sum and average core.
// ----------------------------------------------------------------------------
package dtsa_pkg;

    localparam int CH_W   = 8;
    localparam int CUR_W  = 44;
    localparam int SUM_W  = 52;
    localparam int CNT_W  = 7;
    localparam int POS_W  = 8;
    localparam int FD_W   = 3;
    localparam int POW_W  = 24;
    localparam int TERM_W = 28;
    localparam int CAND_W = CUR_W + 4;
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [CH_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CH_W-1:0] CH_NINE  = 8'd57;
    localparam logic [CH_W-1:0] CH_DOT   = 8'd46;
    localparam logic [CH_W-1:0] CH_SPACE = 8'd32;

    localparam logic [CUR_W-1:0] CUR_MAX = {CUR_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    typedef struct packed {
        logic beat;     // a character beat is taken this cycle
        logic finish;   // close the line and return to line start
    } parse_ctl_t;

    function automatic logic [POW_W-1:0] pow10_f(input logic [FD_W-1:0] k);
        logic [POW_W-1:0] r;
        unique case (k)
            3'd0: r = 24'd1;
            3'd1: r = 24'd10;
            3'd2: r = 24'd100;
            3'd3: r = 24'd1000;
            3'd4: r = 24'd10000;
            3'd5: r = 24'd100000;
            3'd6: r = 24'd1000000;
            3'd7: r = 24'd10000000;
        endcase
        return r;
    endfunction

endpackage

// File: sv/decimal_token_sum_average_core.sv
// ----------------------------------------------------------------------------
// decimal_token_sum_average_core
// Reads decimal numbers out of a line of ASCII text and reports their
// fixed-point sum, count and truncated average at the end of the line.
//
//   channel | direction | ports                                  | beat
//   s_      | in        | s_ch, s_last                           | one character
//   m_      | out       | m_sum_scaled, m_number_count,          | one line result
//           |           | m_average_scaled, m_no_numbers         |
//
// an ordinary character beat is taken while s_ready is high; after the beat with
// s_last the core closes the line in ST_FIN and runs the bit-serial divider in
// ST_DIV; s_ready returns once the result is loaded into the free output slot
// the result sits in an output register, so the next line can stream in while
// it waits; a new line end waits for the slot before loading
// reset (synchronous, aresetn low) returns to line start with no result held
// ----------------------------------------------------------------------------
module decimal_token_sum_average_core #(
    parameter int LINE_MAX    = 128,
    parameter int FRAC_DIGITS = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [dtsa_pkg::CH_W-1:0]   s_ch,
    input  logic                        s_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [dtsa_pkg::SUM_W-1:0]  m_sum_scaled,
    output logic [dtsa_pkg::CNT_W-1:0]  m_number_count,
    output logic [dtsa_pkg::SUM_W-1:0]  m_average_scaled,
    output logic                        m_no_numbers
);
    import dtsa_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FIN  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic [SUM_W-1:0] held_sum_reg, held_sum_next;
    logic [CNT_W-1:0] held_cnt_reg, held_cnt_next;
    logic [SUM_W-1:0] out_sum_reg, out_sum_next;
    logic [CNT_W-1:0] out_cnt_reg, out_cnt_next;
    logic [SUM_W-1:0] out_avg_reg, out_avg_next;
    logic             out_none_reg, out_none_next;

    parse_ctl_t       pctl;
    logic             beat;
    logic             div_start, div_done;
    logic [SUM_W-1:0] fin_sum, quotient;
    logic [CNT_W-1:0] fin_count;
    logic             held_none;

    assign s_ready     = (state_reg == ST_IDLE);
    assign beat        = s_valid && s_ready;
    assign pctl.beat   = beat;
    assign pctl.finish = (state_reg == ST_FIN);
    assign div_start   = (state_reg == ST_FIN);
    assign held_none   = (held_cnt_reg == '0);

    dtsa_parse #(
        .LINE_MAX    (LINE_MAX),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (pctl),
        .ch        (s_ch),
        .fin_sum   (fin_sum),
        .fin_count (fin_count)
    );

    dtsa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (fin_sum),
        .divisor  (fin_count),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg;
        held_sum_next = held_sum_reg;
        held_cnt_next = held_cnt_reg;
        out_sum_next  = out_sum_reg;
        out_cnt_next  = out_cnt_reg;
        out_avg_next  = out_avg_reg;
        out_none_next = out_none_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (beat && s_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                held_sum_next = fin_sum;
                held_cnt_next = fin_count;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                // load once the previous result has left the slot
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    out_sum_next  = held_sum_reg;
                    out_cnt_next  = held_cnt_reg;
                    out_avg_next  = held_none ? '0 : quotient;
                    out_none_next = held_none;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_sum_reg <= held_sum_next;
        held_cnt_reg <= held_cnt_next;
        out_sum_reg  <= out_sum_next;
        out_cnt_reg  <= out_cnt_next;
        out_avg_reg  <= out_avg_next;
        out_none_reg <= out_none_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_sum_scaled     = out_sum_reg;
    assign m_number_count   = out_cnt_reg;
    assign m_average_scaled = out_avg_reg;
    assign m_no_numbers     = out_none_reg;

endmodule

// File: sv/dtsa_parse.sv
// ----------------------------------------------------------------------------
// dtsa_parse
// Per-character number scanner: builds the current fixed-point value and
// keeps the saturating line sum and number count.
// ----------------------------------------------------------------------------
module dtsa_parse #(
    parameter int LINE_MAX    = 128,
    parameter int FRAC_DIGITS = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dtsa_pkg::parse_ctl_t        ctl,
    input  logic [dtsa_pkg::CH_W-1:0]   ch,
    output logic [dtsa_pkg::SUM_W-1:0]  fin_sum,
    output logic [dtsa_pkg::CNT_W-1:0]  fin_count
);
    import dtsa_pkg::*;

    localparam logic [POW_W-1:0] SCALE = pow10_f(FD_W'(FRAC_DIGITS));

    logic             after_sep_reg, after_sep_next;
    logic             in_num_reg, in_num_next;
    logic             point_reg, point_next;
    logic             ended_reg, ended_next;
    logic [FD_W-1:0]  fd_reg, fd_next;
    logic [CUR_W-1:0] cur_reg, cur_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic              is_digit, is_dot;
    logic [CH_W-1:0]   digit_full;
    logic [3:0]        digit;
    logic [FD_W-1:0]   fd_inc;
    logic [TERM_W-1:0] int_term, frac_term;
    logic [CAND_W-1:0] cur_ext, cand;
    logic [CUR_W-1:0]  cur_upd;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  sum_sat;
    logic [CNT_W-1:0]  cnt_inc;

    assign is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_dot     = (ch == CH_DOT);
    assign digit_full = ch - CH_ZERO;
    assign digit      = is_digit ? digit_full[3:0] : 4'd0;
    assign fd_inc     = fd_reg + FD_W'(1);

    assign int_term  = TERM_W'(digit) * TERM_W'(SCALE);
    assign frac_term = TERM_W'(digit) * TERM_W'(pow10_f(FD_W'(FRAC_DIGITS) - fd_inc));

    // integer digit: cur*10 + d*scale, fraction digit: cur + d*10^(frac-k)
    assign cur_ext = CAND_W'(cur_reg);
    assign cand    = point_reg ? (cur_ext + CAND_W'(frac_term))
                               : ((cur_ext << 3) + (cur_ext << 1) + CAND_W'(int_term));
    assign cur_upd = (|cand[CAND_W-1:CUR_W]) ? CUR_MAX : cand[CUR_W-1:0];

    assign sum_add = {1'b0, sum_reg} + (SUM_W+1)'(cur_reg);
    assign sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    assign cnt_inc = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + CNT_W'(1);

    assign fin_sum   = in_num_reg ? sum_sat : sum_reg;
    assign fin_count = in_num_reg ? cnt_inc : cnt_reg;

    always_comb begin
        after_sep_next = after_sep_reg;
        in_num_next    = in_num_reg;
        point_next     = point_reg;
        ended_next     = ended_reg;
        fd_next        = fd_reg;
        cur_next       = cur_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        if (ctl.finish) begin
            after_sep_next = 1'b1;
            in_num_next    = 1'b0;
            point_next     = 1'b0;
            ended_next     = 1'b0;
            fd_next        = '0;
            cur_next       = '0;
            sum_next       = '0;
            cnt_next       = '0;
            pos_next       = '0;
        end else if (ctl.beat) begin
            if (pos_reg < POS_W'(LINE_MAX)) begin
                if (in_num_reg) begin
                    if (is_digit) begin
                        if (!ended_reg) begin
                            if (!point_reg) begin
                                cur_next = cur_upd;
                            end else if (fd_reg < FD_W'(FRAC_DIGITS)) begin
                                fd_next  = fd_inc;
                                cur_next = cur_upd;
                            end
                        end
                    end else if (is_dot) begin
                        // a second dot closes the value, later digits are dropped
                        if (point_reg) begin
                            ended_next = 1'b1;
                        end else begin
                            point_next = 1'b1;
                        end
                    end else begin
                        sum_next    = sum_sat;
                        cnt_next    = cnt_inc;
                        in_num_next = 1'b0;
                        point_next  = 1'b0;
                        ended_next  = 1'b0;
                        fd_next     = '0;
                        cur_next    = '0;
                    end
                end else if (is_digit && after_sep_reg) begin
                    in_num_next = 1'b1;
                    point_next  = 1'b0;
                    ended_next  = 1'b0;
                    fd_next     = '0;
                    cur_next    = CUR_W'(int_term);
                end
                after_sep_next = (ch == CH_SPACE);
            end
            if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_sep_reg <= 1'b1;
            in_num_reg    <= 1'b0;
            point_reg     <= 1'b0;
            ended_reg     <= 1'b0;
            fd_reg        <= '0;
            cur_reg       <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
        end else begin
            after_sep_reg <= after_sep_next;
            in_num_reg    <= in_num_next;
            point_reg     <= point_next;
            ended_reg     <= ended_next;
            fd_reg        <= fd_next;
            cur_reg       <= cur_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
        end
    end

endmodule

// File: sv/dtsa_div.sv
// ----------------------------------------------------------------------------
// dtsa_div
// Restoring divider, one quotient bit per cycle: line sum over number count.
// ----------------------------------------------------------------------------
module dtsa_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [dtsa_pkg::SUM_W-1:0]  dividend,
    input  logic [dtsa_pkg::CNT_W-1:0]  divisor,
    output logic                        done,
    output logic [dtsa_pkg::SUM_W-1:0]  quotient
);
    import dtsa_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [SUM_W-1:0]  q_reg, q_next;

    logic [CNT_W:0]    shifted, diff;
    logic              ge;

    // the compare-and-subtract unit used by every step
    assign shifted = {rem_reg, q_reg[SUM_W-1]};
    assign ge      = shifted >= {1'b0, div_reg};
    assign diff    = shifted - {1'b0, div_reg};

    assign done     = done_reg;
    assign quotient = q_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        q_next    = q_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            div_next  = divisor;
            q_next    = dividend;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            q_next    = {q_reg[SUM_W-2:0], ge};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        q_reg   <= q_next;
    end

endmodule
